[hdl/wtlf_pkg.sv]
package wtlf_pkg;

   // Default depth of the word buffer
   localparam int DEF_DEPTH = 16;

   // Field and register widths
   localparam int CHAR_W = 8;
   localparam int MASK_W = 26;
   localparam int LEN_CFG_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = MASK_W;

   // Width used for length arithmetic and compares (covers depth up to 64 and +1)
   localparam int CMP_W = 8;

   // Letter range
   localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_Z = 8'h7A;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN = 2'd2;

   // Register reset values
   localparam logic [MASK_W-1:0] RST_LETTER_MASK = 26'h2FFFFFF;
   localparam logic [LEN_CFG_W-1:0] RST_MIN_LEN = 5'd3;
   localparam logic [LEN_CFG_W-1:0] RST_MAX_LEN = 5'd10;

   // Commands from controller to datapath
   typedef struct packed {
      logic store;    // write accepted letter, bump length (or set discard mark at the limit)
      logic clear;    // clear length and discard mark
      logic start;    // reset read pointer for emission
      logic read;     // issue buffer read at read pointer
      logic load;     // load output register from buffer data
      logic advance;  // step read pointer
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_letter;
      logic discard;
      logic emit_ok;
      logic ptr_last;
      logic out_free;
   } dp_status_type;

endpackage

[hdl/word_tokenizer_length_filter.sv]
// Word tokenizer with length filter.
// Input channel (req_valid / req_stall / req_in_char) takes one text byte per
// transfer. A lowercase letter whose bit is set in the letter mask joins the
// current word; any other byte ends it. Result channel (rsp_valid / rsp_stall /
// rsp_out_char / rsp_word_last) returns the kept words one character per
// transfer, in text order, with rsp_word_last on the final character.
// Configuration port (csr_write_en / csr_index / csr_write_data): index 0 letter
// mask, 1 minimum length, 2 discard length; write only while the block is idle.
// A letter or a dropped delimiter does not stall the input. A delimiter that
// emits a word holds req_stall until the word has been read out: each
// character is one read of the word buffer plus one load of the output
// register, and a load waits while the receiver stalls the output register.
// The first character of a word is read from the buffer in the read state and
// then loaded into the output register in the load state when that is free.
// Reset clears the word length, the discard mark and the output valid, and
// restores the register defaults. When the receiver stalls, the current
// character holds in the output register and the block stalls its input until
// the last character of the word has been loaded into the output register.
module word_tokenizer_length_filter import wtlf_pkg::*; #(
   parameter int WORD_BUFFER_DEPTH = DEF_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_in_char,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_out_char,
   output logic                  rsp_word_last
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   wtlf_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .cmd(cmd),
      .status(status)
   );

   wtlf_dp #(
      .WORD_BUFFER_DEPTH(WORD_BUFFER_DEPTH)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_in_char(req_in_char),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_out_char(rsp_out_char),
      .rsp_word_last(rsp_word_last),
      .cmd(cmd),
      .status(status)
   );

endmodule

[hdl/wtlf_ram.sv]
module wtlf_ram import wtlf_pkg::*; #(
   parameter int WIDTH = CHAR_W,
   parameter int DEPTH = DEF_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/wtlf_dp.sv]
module wtlf_dp import wtlf_pkg::*; #(
   parameter int WORD_BUFFER_DEPTH = DEF_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [CHAR_W-1:0]     req_in_char,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [CHAR_W-1:0]     rsp_out_char,
   output logic                  rsp_word_last,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status
);

   localparam int ADDR_W = $clog2(WORD_BUFFER_DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(WORD_BUFFER_DEPTH);

   logic [MASK_W-1:0]    letter_mask_ff;
   logic [LEN_CFG_W-1:0] min_len_ff;
   logic [LEN_CFG_W-1:0] max_len_ff;
   logic [ADDR_W-1:0]    word_len_ff, word_len_in;
   logic                 discard_ff, discard_in;
   logic [ADDR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff;
   logic                 rsp_last_ff;
   logic [CHAR_W-1:0]    ram_rd_data;
   logic [LEN_CFG_W-1:0] letter_idx;
   logic [CMP_W-1:0]     limit;
   logic [CMP_W-1:0]     len_plus;
   logic                 in_range;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         letter_mask_ff <= RST_LETTER_MASK;
         min_len_ff <= RST_MIN_LEN;
         max_len_ff <= RST_MAX_LEN;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LETTER_MASK: letter_mask_ff <= csr_write_data[MASK_W-1:0];
            CSR_MIN_LEN:     min_len_ff <= csr_write_data[LEN_CFG_W-1:0];
            CSR_MAX_LEN:     max_len_ff <= csr_write_data[LEN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Letter classification
   assign in_range = (req_in_char >= CHAR_A) && (req_in_char <= CHAR_Z);
   assign letter_idx = LEN_CFG_W'(req_in_char - CHAR_A);
   assign status.is_letter = in_range && letter_mask_ff[letter_idx];

   // Discard limit saturates to the buffer depth
   always_comb begin
      if ((max_len_ff == '0) || (CMP_W'(max_len_ff) > DEPTH_C)) begin
         limit = DEPTH_C;
      end else begin
         limit = CMP_W'(max_len_ff);
      end
   end

   assign len_plus = CMP_W'(word_len_ff) + CMP_W'(1);

   // Word length and discard mark
   always_comb begin
      word_len_in = word_len_ff;
      discard_in = discard_ff;
      if (cmd.clear) begin
         word_len_in = '0;
         discard_in = 1'b0;
      end else if (cmd.store) begin
         if (len_plus >= limit) begin
            word_len_in = '0;
            discard_in = 1'b1;
         end else begin
            word_len_in = len_plus[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_len_ff <= '0;
         discard_ff <= 1'b0;
      end else begin
         word_len_ff <= word_len_in;
         discard_ff <= discard_in;
      end
   end

   assign status.discard = discard_ff;
   assign status.emit_ok = (word_len_ff != '0) &&
                           (CMP_W'(word_len_ff) >= CMP_W'(min_len_ff));

   // Read pointer for emission
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (cmd.start) begin
         rd_ptr_in = '0;
      end else if (cmd.advance) begin
         rd_ptr_in = rd_ptr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   assign status.ptr_last = (CMP_W'(rd_ptr_ff) + CMP_W'(1)) == CMP_W'(word_len_ff);

   // Word buffer
   wtlf_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(WORD_BUFFER_DEPTH)
   ) u_buf (
      .clock(clock),
      .wr_en(cmd.store),
      .wr_addr(word_len_ff),
      .wr_data(req_in_char),
      .rd_en(cmd.read),
      .rd_addr(rd_ptr_ff),
      .rd_data(ram_rd_data)
   );

   // Output register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_char_ff <= ram_rd_data;
         rsp_last_ff <= status.ptr_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_word_last = rsp_last_ff;

   // Length never reaches the buffer depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(word_len_ff) < DEPTH_C)
      else $error("word length reached buffer depth");

   // Reads stay inside the current word
   a_read_in_word: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> (CMP_W'(rd_ptr_ff) < CMP_W'(word_len_ff)))
      else $error("buffer read beyond current word");

endmodule

[hdl/wtlf_ctrl.sv]
module wtlf_ctrl import wtlf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.is_letter) begin
                  cmd.store = 1'b1;
               end else if (!status.discard && status.emit_ok) begin
                  cmd.start = 1'b1;
                  state_in = ST_READ;
               end else begin
                  cmd.clear = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               if (status.ptr_last) begin
                  cmd.clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Every buffer read is followed by the load state
   a_read_then_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_LOAD))
      else $error("read not followed by load");

   // Output register is only loaded when it is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("output register overwritten");

endmodule
